// ----- rtl/mls_pkg.sv -----
// ----------------------------------------------------------------------------
// mls_pkg
// Shared types, codes and widths of the multi-list store.
// ----------------------------------------------------------------------------
package mls_pkg;

   localparam int NUM_LISTS_DEF = 10;
   localparam int LIST_CAP_DEF  = 4;

   localparam int ACT_W = 4;
   localparam int SLOT_W = 4;
   localparam int AMT_W = 5;
   localparam int VAL_W = 32;
   localparam int STS_W = 4;
   localparam int CNT_W = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_CREATE          = 4'd0,
      ACT_APPEND          = 4'd1,
      ACT_DROP_LAST       = 4'd2,
      ACT_REMOVE          = 4'd3,
      ACT_RESIZE          = 4'd4,
      ACT_COUNT           = 4'd5,
      ACT_READ            = 4'd6,
      ACT_READ_SORTED     = 4'd7,
      ACT_READ_ALL        = 4'd8,
      ACT_READ_ALL_SORTED = 4'd9
   } action_type;

   typedef enum logic [STS_W-1:0] {
      ST_OK        = 4'd0,
      ST_BAD_SLOT  = 4'd1,
      ST_EXISTS    = 4'd2,
      ST_BAD_SIZE  = 4'd3,
      ST_NO_LIST   = 4'd4,
      ST_FULL      = 4'd5,
      ST_EMPTY     = 4'd6,
      ST_NOT_FOUND = 4'd7,
      ST_ALL_EMPTY = 4'd8,
      ST_BAD_NEW   = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_SINGLE,
      MODE_READ,
      MODE_SORT,
      MODE_REMOVE
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_EMIT_WAIT,
      S_SH_CHK,
      S_SH_RD,
      S_SH_WR
   } state_type;

   typedef struct packed {
      logic latch;
      logic commit;
      logic scan_start;
      logic rd_issue;
      logic advance;
      logic restart;
      logic take_best;
      logic found;
      logic sh_rd;
      logic sh_wr;
      logic rsp_single;
      logic rsp_notfound;
      logic rsp_elem;
      logic rsp_best;
      logic rm_done;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      mode_type run_mode;
      logic     rsp_busy;
      logic     tag;
      logic     match;
      logic     better;
      logic     cursor_end;
      logic     all_out;
      logic     shift_done;
   } stat_type;

endpackage

// ----- rtl/mls_ifs.sv -----
// ----------------------------------------------------------------------------
// mls_ifs
// Request and response channels of the multi-list store.
// ----------------------------------------------------------------------------
interface mls_req_if;
   logic                             valid;
   logic                             ready;
   logic [mls_pkg::ACT_W-1:0]        action;
   logic [mls_pkg::SLOT_W-1:0]       slot;
   logic signed [mls_pkg::AMT_W-1:0] amount;
   logic signed [mls_pkg::VAL_W-1:0] value;

   modport source (output valid, action, slot, amount, value, input ready);
   modport sink (input valid, action, slot, amount, value, output ready);
endinterface

interface mls_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mls_pkg::STS_W-1:0]        status;
   logic                             has_value;
   logic signed [mls_pkg::VAL_W-1:0] element;
   logic [mls_pkg::CNT_W-1:0]        count;
   logic                             last;

   modport source (output valid, status, has_value, element, count, last, input ready);
   modport sink (input valid, status, has_value, element, count, last, output ready);
endinterface

// ----- rtl/mls_ctrl.sv -----
// ----------------------------------------------------------------------------
// mls_ctrl
// Sequencer: steps each transaction through decode, scan, emit and shift.
// ----------------------------------------------------------------------------
module mls_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mls_pkg::stat_type stat,
   output mls_pkg::cmd_type  cmd
);
   import mls_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !stat.rsp_busy;
            if (req_valid && !stat.rsp_busy) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (stat.mode)
               MODE_NONE: state_in = S_IDLE;
               MODE_SINGLE: begin
                  cmd.commit     = 1'b1;
                  cmd.rsp_single = 1'b1;
                  state_in       = S_IDLE;
               end
               default: begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN_RD;
               end
            endcase
         end
         S_SCAN_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            unique case (stat.run_mode)
               MODE_READ: begin
                  if (stat.tag) begin
                     cmd.rsp_elem = 1'b1;
                     state_in     = S_EMIT_WAIT;
                  end else if (stat.cursor_end) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_SCAN_RD;
                  end
               end
               MODE_SORT: begin
                  cmd.take_best = stat.better && !stat.cursor_end;
                  if (stat.cursor_end) begin
                     cmd.rsp_best = 1'b1;
                     state_in     = S_EMIT_WAIT;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_SCAN_RD;
                  end
               end
               MODE_REMOVE: begin
                  if (stat.tag && stat.match) begin
                     cmd.found = 1'b1;
                     state_in  = S_SH_CHK;
                  end else if (stat.cursor_end) begin
                     cmd.rsp_notfound = 1'b1;
                     state_in         = S_IDLE;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_SCAN_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_EMIT_WAIT: begin
            if (!stat.rsp_busy) begin
               if (stat.all_out) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.advance = (stat.run_mode == MODE_READ);
                  cmd.restart = (stat.run_mode == MODE_SORT);
                  state_in    = S_SCAN_RD;
               end
            end
         end
         S_SH_CHK: begin
            if (stat.shift_done) begin
               cmd.rm_done = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_SH_RD;
            end
         end
         S_SH_RD: begin
            cmd.sh_rd = 1'b1;
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            cmd.sh_wr = 1'b1;
            state_in  = S_SH_CHK;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- rtl/mls_dp.sv -----
// ----------------------------------------------------------------------------
// mls_dp
// Datapath: list descriptors, element memory, scan cursor, sort keys and
// response register.
// ----------------------------------------------------------------------------
module mls_dp #(
   parameter int NUM_LISTS = mls_pkg::NUM_LISTS_DEF,
   parameter int LIST_CAP  = mls_pkg::LIST_CAP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mls_pkg::cmd_type                 cmd,
   output mls_pkg::stat_type                stat,
   input  logic [mls_pkg::ACT_W-1:0]        req_action,
   input  logic [mls_pkg::SLOT_W-1:0]       req_slot,
   input  logic signed [mls_pkg::AMT_W-1:0] req_amount,
   input  logic signed [mls_pkg::VAL_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mls_pkg::STS_W-1:0]        rsp_status,
   output logic                             rsp_has_value,
   output logic signed [mls_pkg::VAL_W-1:0] rsp_element,
   output logic [mls_pkg::CNT_W-1:0]        rsp_count,
   output logic                             rsp_last
);
   import mls_pkg::*;

   localparam int DEPTH = NUM_LISTS * LIST_CAP;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int IW = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
   localparam int TW = $clog2(DEPTH + 1);

   logic [ACT_W-1:0]        act_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic signed [AMT_W-1:0] amt_ff;
   logic [VAL_W-1:0]        val_ff;

   logic [CNT_W-1:0] cap_ff [NUM_LISTS];
   logic [CNT_W-1:0] fill_ff [NUM_LISTS];

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rdata_ff;
   logic             tag_ff;
   logic [AW-1:0]    pos_ff;

   logic [SW-1:0] cur_s_ff;
   logic [IW-1:0] cur_i_ff;
   logic [IW-1:0] j_ff;
   logic [TW-1:0] k_ff;
   logic [TW-1:0] total_ff;
   mode_type      mode_ff;

   logic [VAL_W-1:0] best_val_ff, prev_val_ff;
   logic [AW-1:0]    best_pos_ff, prev_pos_ff;
   logic             best_ok_ff, prev_ok_ff;

   logic             rsp_valid_ff;
   logic [STS_W-1:0] rsp_status_ff;
   logic             rsp_hv_ff;
   logic [VAL_W-1:0] rsp_el_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;
   logic             rsp_last_ff;

   logic             slot_ok, all_sel;
   logic [SW-1:0]    idx;
   logic [CNT_W-1:0] cap_sel, fill_sel;
   logic [TW-1:0]    sum_all;
   logic signed [7:0] amt_x, nc;
   mode_type         dec_mode;
   status_type       dec_status;
   logic [CNT_W-1:0] dec_count;
   logic [AW-1:0]    base_idx, scan_addr, sh_addr, rd_addr, wr_addr;
   logic             wr_en;
   logic [VAL_W-1:0] wr_data;
   logic             better, last_out, rsp_load;
   logic [VAL_W-1:0] sel_val;
   logic [AW-1:0]    sel_pos;
   logic             fill_over;

   function automatic logic key_gt(logic [VAL_W-1:0] av, logic [AW-1:0] ap,
                                   logic [VAL_W-1:0] bv, logic [AW-1:0] bp);
      return ($signed(av) > $signed(bv)) || ((av == bv) && (ap > bp));
   endfunction

   assign slot_ok  = (slot_ff != '0) && (slot_ff <= SLOT_W'(NUM_LISTS));
   assign idx      = SW'(slot_ff - SLOT_W'(1));
   assign cap_sel  = slot_ok ? cap_ff[idx] : '0;
   assign fill_sel = slot_ok ? fill_ff[idx] : '0;
   assign all_sel  = (act_ff == ACT_READ_ALL) || (act_ff == ACT_READ_ALL_SORTED);
   assign amt_x    = 8'(amt_ff);
   assign nc       = $signed({5'd0, cap_sel}) + amt_x;

   always_comb begin
      sum_all = '0;
      for (int l = 0; l < NUM_LISTS; l++) begin
         sum_all = sum_all + TW'(fill_ff[l]);
      end
   end

   always_comb begin
      dec_mode   = MODE_SINGLE;
      dec_status = ST_OK;
      dec_count  = '0;
      if (act_ff > ACT_READ_ALL_SORTED) begin
         dec_mode = MODE_NONE;
      end else if (all_sel) begin
         if (sum_all == '0) begin
            dec_status = ST_ALL_EMPTY;
         end else begin
            dec_mode = (act_ff == ACT_READ_ALL) ? MODE_READ : MODE_SORT;
         end
      end else if (!slot_ok) begin
         dec_status = ST_BAD_SLOT;
      end else if (act_ff == ACT_CREATE) begin
         if (cap_sel != '0) begin
            dec_status = ST_EXISTS;
         end else if (amt_x < 8'sd1 || amt_x > 8'(LIST_CAP)) begin
            dec_status = ST_BAD_SIZE;
         end
      end else if (cap_sel == '0) begin
         dec_status = ST_NO_LIST;
      end else begin
         priority case (action_type'(act_ff))
            ACT_APPEND: begin
               if (fill_sel >= cap_sel) dec_status = ST_FULL;
            end
            ACT_DROP_LAST: begin
               if (fill_sel == '0) dec_status = ST_EMPTY;
            end
            ACT_REMOVE: begin
               if (fill_sel == '0) dec_status = ST_EMPTY;
               else dec_mode = MODE_REMOVE;
            end
            ACT_RESIZE: begin
               if (nc < 8'sd1 || nc > 8'(LIST_CAP)) dec_status = ST_BAD_NEW;
            end
            ACT_COUNT: begin
               if (fill_sel == '0) dec_status = ST_EMPTY;
               else dec_count = fill_sel;
            end
            default: begin
               if (fill_sel != '0) begin
                  dec_mode = (act_ff == ACT_READ) ? MODE_READ : MODE_SORT;
               end
            end
         endcase
      end
   end

   assign base_idx  = AW'(idx * LIST_CAP);
   assign scan_addr = AW'(cur_s_ff * LIST_CAP) + AW'(cur_i_ff);
   assign sh_addr   = base_idx + AW'(j_ff) + AW'(1);
   assign rd_addr   = cmd.sh_rd ? sh_addr : scan_addr;
   assign wr_en     = (cmd.commit && dec_status == ST_OK && act_ff == ACT_APPEND) || cmd.sh_wr;
   assign wr_addr   = cmd.sh_wr ? (base_idx + AW'(j_ff)) : (base_idx + AW'(fill_sel));
   assign wr_data   = cmd.sh_wr ? rdata_ff : val_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_issue || cmd.sh_rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign better = tag_ff && (!prev_ok_ff || key_gt(rdata_ff, pos_ff, prev_val_ff, prev_pos_ff))
                   && (!best_ok_ff || key_gt(best_val_ff, best_pos_ff, rdata_ff, pos_ff));
   assign sel_val  = better ? rdata_ff : best_val_ff;
   assign sel_pos  = better ? pos_ff : best_pos_ff;
   assign last_out = ((k_ff + TW'(1)) == total_ff);
   assign rsp_load = cmd.rsp_single || cmd.rsp_notfound || cmd.rsp_elem
                     || cmd.rsp_best || cmd.rm_done;

   // descriptors and sequencing state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LISTS; l++) begin
            cap_ff[l]  <= '0;
            fill_ff[l] <= '0;
         end
         mode_ff    <= MODE_NONE;
         k_ff       <= '0;
         total_ff   <= '0;
         best_ok_ff <= 1'b0;
         prev_ok_ff <= 1'b0;
         cur_s_ff   <= '0;
         cur_i_ff   <= '0;
         j_ff       <= '0;
      end else begin
         if (cmd.commit && dec_status == ST_OK && dec_mode == MODE_SINGLE) begin
            priority case (action_type'(act_ff))
               ACT_CREATE: begin
                  cap_ff[idx]  <= CNT_W'(amt_ff);
                  fill_ff[idx] <= '0;
               end
               ACT_APPEND:    fill_ff[idx] <= fill_sel + CNT_W'(1);
               ACT_DROP_LAST: fill_ff[idx] <= fill_sel - CNT_W'(1);
               ACT_RESIZE: begin
                  cap_ff[idx] <= CNT_W'(nc);
                  if ($signed({5'd0, fill_sel}) > nc) fill_ff[idx] <= CNT_W'(nc);
               end
               default: ;
            endcase
         end
         if (cmd.scan_start) begin
            mode_ff    <= dec_mode;
            cur_s_ff   <= all_sel ? '0 : idx;
            cur_i_ff   <= '0;
            k_ff       <= '0;
            total_ff   <= all_sel ? sum_all : TW'(fill_sel);
            best_ok_ff <= 1'b0;
            prev_ok_ff <= 1'b0;
         end
         if (cmd.advance) begin
            if (cur_i_ff == IW'(LIST_CAP - 1)) begin
               cur_i_ff <= '0;
               cur_s_ff <= cur_s_ff + SW'(1);
            end else begin
               cur_i_ff <= cur_i_ff + IW'(1);
            end
         end
         if (cmd.restart) begin
            cur_s_ff <= all_sel ? '0 : idx;
            cur_i_ff <= '0;
         end
         if (cmd.take_best) begin
            best_val_ff <= rdata_ff;
            best_pos_ff <= pos_ff;
            best_ok_ff  <= 1'b1;
         end
         if (cmd.rsp_best) begin
            prev_val_ff <= sel_val;
            prev_pos_ff <= sel_pos;
            prev_ok_ff  <= 1'b1;
            best_ok_ff  <= 1'b0;
         end
         if (cmd.rsp_elem || cmd.rsp_best) begin
            k_ff <= k_ff + TW'(1);
         end
         if (cmd.found) begin
            j_ff <= cur_i_ff;
         end
         if (cmd.sh_wr) begin
            j_ff <= j_ff + IW'(1);
         end
         if (cmd.rm_done) begin
            fill_ff[idx] <= fill_sel - CNT_W'(1);
         end
      end
   end

   // request capture and scan tags
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff  <= req_action;
         slot_ff <= req_slot;
         amt_ff  <= req_amount;
         val_ff  <= req_value;
      end
      if (cmd.rd_issue) begin
         tag_ff <= (fill_ff[cur_s_ff] > CNT_W'(cur_i_ff));
         pos_ff <= scan_addr;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hv_ff   <= cmd.rsp_elem || cmd.rsp_best;
         rsp_cnt_ff  <= cmd.rsp_single ? dec_count : '0;
         rsp_last_ff <= (cmd.rsp_elem || cmd.rsp_best) ? last_out : 1'b1;
         priority if (cmd.rsp_single) begin
            rsp_status_ff <= dec_status;
            rsp_el_ff     <= '0;
         end else if (cmd.rsp_notfound) begin
            rsp_status_ff <= ST_NOT_FOUND;
            rsp_el_ff     <= '0;
         end else if (cmd.rsp_elem) begin
            rsp_status_ff <= ST_OK;
            rsp_el_ff     <= rdata_ff;
         end else if (cmd.rsp_best) begin
            rsp_status_ff <= ST_OK;
            rsp_el_ff     <= sel_val;
         end else begin
            rsp_status_ff <= ST_OK;
            rsp_el_ff     <= '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_has_value = rsp_hv_ff;
   assign rsp_element   = rsp_el_ff;
   assign rsp_count     = rsp_cnt_ff;
   assign rsp_last      = rsp_last_ff;

   assign stat.mode       = dec_mode;
   assign stat.run_mode   = mode_ff;
   assign stat.rsp_busy   = rsp_valid_ff;
   assign stat.tag        = tag_ff;
   assign stat.match      = (rdata_ff == val_ff);
   assign stat.better     = better;
   assign stat.cursor_end = (cur_i_ff == IW'(LIST_CAP - 1))
                            && (!all_sel || cur_s_ff == SW'(NUM_LISTS - 1));
   assign stat.all_out    = (k_ff == total_ff);
   assign stat.shift_done = (CNT_W'(j_ff) == (fill_sel - CNT_W'(1)));

   always_comb begin
      fill_over = 1'b0;
      for (int l = 0; l < NUM_LISTS; l++) begin
         fill_over = fill_over | (fill_ff[l] > cap_ff[l]);
      end
   end

   a_fill_within_cap: assert property (@(posedge clock) disable iff (reset)
      !fill_over)
      else $error("list fill above its capacity");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_elem || cmd.rsp_best) |-> (k_ff < total_ff))
      else $error("more elements emitted than stored");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff)
      else $error("response loaded over a pending one");

endmodule

// ----- rtl/multi_list_store.sv -----
// ----------------------------------------------------------------------------
// multi_list_store
// Numbered bounded lists of signed words with create, append, drop-last,
// remove, resize, count and plain or sorted read-out.
//
//   channel  direction  handshake     payload
//   req_ch   in         valid/ready   action, slot, amount, value
//   rsp_ch   out        valid/ready   status, has_value, element, count, last
//
// One transaction at a time. A result that needs no scan is loaded into the
// output register from the execute state; the next transaction is taken once
// the sequencer is idle and the output register is empty. Reads scan up to
// LIST_CAP positions per list in range, each a memory read then a check, and
// emit each element found; a sorted read repeats the whole scan per element.
// Remove scans for the value, then shifts each later element down one place.
// A result waits in the output register; each stalled cycle holds the sequencer.
// Reset clears all lists; element memory is not cleared.
// ----------------------------------------------------------------------------
module multi_list_store #(
   parameter int NUM_LISTS = mls_pkg::NUM_LISTS_DEF,
   parameter int LIST_CAP  = mls_pkg::LIST_CAP_DEF
) (
   input logic       clock,
   input logic       reset,
   mls_req_if.sink   req_ch,
   mls_rsp_if.source rsp_ch
);
   import mls_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mls_dp #(
      .NUM_LISTS (NUM_LISTS),
      .LIST_CAP  (LIST_CAP)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (req_ch.action),
      .req_slot      (req_ch.slot),
      .req_amount    (req_ch.amount),
      .req_value     (req_ch.value),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_status    (rsp_ch.status),
      .rsp_has_value (rsp_ch.has_value),
      .rsp_element   (rsp_ch.element),
      .rsp_count     (rsp_ch.count),
      .rsp_last      (rsp_ch.last)
   );

endmodule

// ----- bench/mls_tb_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mls_tb_checker
// Watches both channels of the multi-list store, keeps its own copy of the
// lists, works out the responses of every accepted request and compares them
// field by field, in order, with the responses the block returns.
// ----------------------------------------------------------------------------
module mls_tb_checker #(
   parameter int NUM_LISTS = mls_pkg::NUM_LISTS_DEF,
   parameter int LIST_CAP  = mls_pkg::LIST_CAP_DEF
) (
   input logic     clock,
   input logic     reset,
   mls_req_if.sink req_ch,
   mls_rsp_if.sink rsp_ch,
   output int      fail_count,
   output int      pending,
   output int      rsp_seen
);
   import mls_pkg::*;

   typedef struct packed {
      status_type       status;
      logic             has_value;
      logic [VAL_W-1:0] element;
      logic [CNT_W-1:0] count;
      logic             last;
   } answer_type;

   answer_type   answers[$];
   int           cap_of[NUM_LISTS];
   int           fill_of[NUM_LISTS];
   logic [31:0]  words[NUM_LISTS*LIST_CAP];

   initial pending = 0;

   function automatic answer_type make(status_type st, logic hv, logic [31:0] el,
                                       int cnt, logic lst);
      answer_type a;
      a.status = st; a.has_value = hv; a.element = el;
      a.count = cnt[CNT_W-1:0]; a.last = lst;
      return a;
   endfunction

   task automatic post(status_type st, int cnt);
      answers.push_back(make(st, 1'b0, '0, cnt, 1'b1));
   endtask

   task automatic post_list(logic [31:0] v[$], bit ascending);
      logic [31:0] t;
      if (ascending)
         for (int i = 0; i < v.size(); i++)
            for (int j = i + 1; j < v.size(); j++)
               if ($signed(v[i]) > $signed(v[j])) begin
                  t = v[i]; v[i] = v[j]; v[j] = t;
               end
      if (v.size() == 0) post(ST_OK, 0);
      for (int k = 0; k < v.size(); k++)
         answers.push_back(make(ST_OK, 1'b1, v[k], 0, k == v.size() - 1));
   endtask

   task automatic apply_request(logic [3:0] act, logic [3:0] slot,
                                logic signed [4:0] amt, logic [31:0] val);
      logic [31:0] gathered[$];
      int idx, base, n, i, nc;
      if (act > ACT_READ_ALL_SORTED) return;
      if (act == ACT_READ_ALL || act == ACT_READ_ALL_SORTED) begin
         for (int s = 0; s < NUM_LISTS; s++)
            for (int k = 0; k < fill_of[s]; k++) gathered.push_back(words[s*LIST_CAP+k]);
         if (gathered.size() == 0) post(ST_ALL_EMPTY, 0);
         else post_list(gathered, act == ACT_READ_ALL_SORTED);
         return;
      end
      if (slot < 1 || slot > NUM_LISTS) begin post(ST_BAD_SLOT, 0); return; end
      idx = slot - 1;
      base = idx * LIST_CAP;
      if (act == ACT_CREATE) begin
         if (cap_of[idx] != 0) post(ST_EXISTS, 0);
         else if (amt < 1 || amt > LIST_CAP) post(ST_BAD_SIZE, 0);
         else begin
            cap_of[idx] = amt; fill_of[idx] = 0; post(ST_OK, 0);
         end
         return;
      end
      if (cap_of[idx] == 0) begin post(ST_NO_LIST, 0); return; end
      n = fill_of[idx];
      case (act)
         ACT_APPEND: begin
            if (n >= cap_of[idx]) post(ST_FULL, 0);
            else begin
               words[base+n] = val; fill_of[idx] = n + 1; post(ST_OK, 0);
            end
         end
         ACT_DROP_LAST: begin
            if (n == 0) post(ST_EMPTY, 0);
            else begin fill_of[idx] = n - 1; post(ST_OK, 0); end
         end
         ACT_REMOVE: begin
            if (n == 0) post(ST_EMPTY, 0);
            else begin
               for (i = 0; i < n; i++) if (words[base+i] == val) break;
               if (i == n) post(ST_NOT_FOUND, 0);
               else begin
                  for (; i < n - 1; i++) words[base+i] = words[base+i+1];
                  fill_of[idx] = n - 1; post(ST_OK, 0);
               end
            end
         end
         ACT_RESIZE: begin
            nc = cap_of[idx] + amt;
            if (nc < 1 || nc > LIST_CAP) post(ST_BAD_NEW, 0);
            else begin
               cap_of[idx] = nc;
               if (n > nc) fill_of[idx] = nc;
               post(ST_OK, 0);
            end
         end
         ACT_COUNT: post(n == 0 ? ST_EMPTY : ST_OK, n);
         default: begin
            for (i = 0; i < n; i++) gathered.push_back(words[base+i]);
            post_list(gathered, act == ACT_READ_SORTED);
         end
      endcase
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         answers.delete();
         fail_count <= 0;
         rsp_seen <= 0;
         for (int s = 0; s < NUM_LISTS; s++) begin cap_of[s] = 0; fill_of[s] = 0; end
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (answers.size() == 0) begin
               $error("response with none outstanding: status %0d", rsp_ch.status);
               fail_count <= fail_count + 1;
            end else begin
               want = answers.pop_front();
               if (rsp_ch.status !== want.status
                   || rsp_ch.has_value !== want.has_value
                   || rsp_ch.element !== want.element
                   || rsp_ch.count !== want.count
                   || rsp_ch.last !== want.last)
                  fail_count <= fail_count + 1;
               if (rsp_ch.status !== want.status)
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               if (rsp_ch.has_value !== want.has_value)
                  $error("has_value: expected %0d, got %0d", want.has_value,
                         rsp_ch.has_value);
               if (rsp_ch.element !== want.element)
                  $error("element: expected %0d, got %0d", $signed(want.element),
                         rsp_ch.element);
               if (rsp_ch.count !== want.count)
                  $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
               if (rsp_ch.last !== want.last)
                  $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
            end
         end
         if (req_ch.valid && req_ch.ready)
            apply_request(req_ch.action, req_ch.slot, req_ch.amount, req_ch.value);
      end
      pending <= answers.size();
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the multi-list store with directed and random request transactions
// under random back-pressure and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;
   import mls_pkg::*;

   logic clock;
   logic reset;
   int   fail_count, pending, rsp_seen;
   int   sent;
   logic [31:0] pool[8];

   mls_req_if req_ch ();
   mls_rsp_if rsp_ch ();

   multi_list_store dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   mls_tb_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("TEST FAILED");
      $finish;
   end

   // response side: random stalls, with calm stretches
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   task automatic send(logic [3:0] act, logic [3:0] slot, logic signed [4:0] amt,
                       logic [31:0] val, bit calm);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.slot <= slot;
      req_ch.amount <= amt;
      req_ch.value <= val;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (act <= ACT_READ_ALL_SORTED) sent++;
   endtask

   initial begin
      logic [3:0]  act;
      logic [31:0] val;
      bit          calm;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_CREATE;
      req_ch.slot = '0;
      req_ch.amount = '0;
      req_ch.value = '0;
      sent = 0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
               32'h5, 32'hAAAA_5555, 32'h5555_AAAA, 32'h1};

      // directed
      send(ACT_READ_ALL, 4'd0, 0, 0, 0);
      send(ACT_COUNT, 4'd3, 0, 0, 0);
      send(ACT_CREATE, 4'd0, 2, 0, 0);
      send(ACT_CREATE, 4'd15, 2, 0, 0);
      send(ACT_CREATE, 4'd1, 0, 0, 0);
      send(ACT_CREATE, 4'd1, 5, 0, 0);
      send(ACT_CREATE, 4'd1, -8, 0, 0);
      send(ACT_CREATE, 4'd1, 4, 0, 0);
      send(ACT_CREATE, 4'd1, 2, 0, 0);
      send(ACT_CREATE, 4'd10, 1, 0, 0);
      send(ACT_READ, 4'd1, 0, 0, 0);
      send(ACT_COUNT, 4'd1, 0, 0, 0);
      send(ACT_DROP_LAST, 4'd1, 0, 0, 0);
      send(ACT_REMOVE, 4'd1, 0, 32'h5, 0);
      for (int i = 0; i < 5; i++) send(ACT_APPEND, 4'd1, 0, pool[i], 0);
      send(ACT_APPEND, 4'd10, 0, 32'h8000_0000, 0);
      send(ACT_REMOVE, 4'd1, 0, 32'h1234, 0);
      send(ACT_REMOVE, 4'd1, 0, 32'h7FFF_FFFF, 0);
      send(ACT_READ_SORTED, 4'd1, 0, 0, 0);
      send(ACT_RESIZE, 4'd1, 8, 0, 0);
      send(ACT_RESIZE, 4'd1, -2, 0, 0);
      send(ACT_RESIZE, 4'd10, 3, 0, 0);
      send(ACT_RESIZE, 4'd2, 1, 0, 0);
      send(ACT_READ_ALL_SORTED, 4'd7, 0, 0, 0);
      send(4'd12, 4'd1, 0, 0, 0);

      // random: mostly well-formed on the valid slots, some noise
      while (sent < 345) begin
         calm = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) == 0) act = 4'($urandom_range(0, 15));
         else case ($urandom_range(0, 11))
            0, 1:    act = ACT_CREATE;
            2, 3, 4: act = ACT_APPEND;
            5:       act = ACT_DROP_LAST;
            6:       act = ACT_REMOVE;
            7:       act = ACT_RESIZE;
            8:       act = ACT_COUNT;
            9:       act = 4'($urandom_range(ACT_READ, ACT_READ_SORTED));
            default: act = 4'($urandom_range(ACT_READ_ALL, ACT_READ_ALL_SORTED));
         endcase
         val = ($urandom_range(0, 2) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
         send(act,
              ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 10)),
              ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($signed($urandom_range(0, 7)) - 3),
              val, calm);
      end
      req_ch.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Ran %0d list requests, %0d responses checked, random stalls both sides.",
               sent, rsp_seen);
      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/mls_pkg.sv
rtl/mls_ifs.sv
rtl/mls_ctrl.sv
rtl/mls_dp.sv
rtl/multi_list_store.sv
bench/mls_tb_checker.sv
bench/testbench.sv
